[hw/rtl/hmn_pkg.sv]
// ----------------------------------------------------------------------------
// hmn_pkg
// Shared types and constants for the height-map normal stream.
// ----------------------------------------------------------------------------
package hmn_pkg;

  localparam int MAX_GRID = 128;
  localparam int ADDR_W   = 7;
  localparam int H_W      = 16;
  localparam int Q_W      = 15;
  localparam int S_W      = 34;
  localparam logic [7:0]   GRID_MIN  = 8'd3;
  localparam logic [7:0]   GRID_MAX  = 8'd128;
  localparam logic [7:0]   GRID_RST  = 8'd100;
  localparam logic [16:0]  NY_MAG    = 17'd512;
  localparam logic [S_W-1:0] NY_SQ   = 34'd262144;
  localparam logic [Q_W-1:0] ONE_Q14 = 15'd16384;

  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_RD0,
    OP_RD1,
    OP_WR,
    OP_SQX,
    OP_SQZ,
    OP_MAG,
    OP_MID,
    OP_PL,
    OP_PH,
    OP_QSAVE,
    OP_EMIT1,
    OP_EMIT2,
    OP_ADV
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] comp;
  } dp_cmd_t;

  typedef struct packed {
    logic row_zero;
    logic border;
    logic last_row;
    logic done;
    logic out_free;
  } dp_status_t;

endpackage

[hw/rtl/heightmap_normal_stream.sv]
// ----------------------------------------------------------------------------
// heightmap_normal_stream
// Central-difference unit normals of a square height grid, raster stream.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall / height, one Q8.8 sample per word in
// raster order. Output channel: out_valid / out_stall with normal_x/y/z in
// Q2.14, point_row, point_col and last. The sample at row r, column c gives
// the normal of point (r-1, c); on the final row a second word carries the
// zero border normal of (r, c). Row 0 gives no word.
// cfg_write / cfg_data set grid_size and restart the frame at (0, 0); write
// only while idle.
// Per word: row 0 points only update the line stores; border points give a
// zero word (a second one on the final row), plus any output wait. Interior
// points run the binary search of each component on the one shared
// multiplier (14 or 15 steps, 30x17 product split in two halves).
// Reset clears counters, output valid and sets grid_size to 100. A stalled
// output word holds; the next input word is taken once the sequencer is idle
// again, after the previous one is placed and the position counters advance.
// ----------------------------------------------------------------------------
module heightmap_normal_stream (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] height,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] normal_x,
  output logic [14:0]        normal_y,
  output logic signed [15:0] normal_z,
  output logic [6:0]         point_row,
  output logic [6:0]         point_col,
  output logic               last
);
  import hmn_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  hmn_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .status(status), .cmd(cmd)
  );

  hmn_datapath u_dp (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .height(height), .cmd(cmd), .status(status), .out_stall(out_stall),
    .out_valid(out_valid), .normal_x(normal_x), .normal_y(normal_y),
    .normal_z(normal_z), .point_row(point_row), .point_col(point_col),
    .last(last)
  );

endmodule

[hw/rtl/hmn_ram.sv]
// ----------------------------------------------------------------------------
// hmn_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module hmn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/hmn_ctrl.sv]
// ----------------------------------------------------------------------------
// hmn_ctrl
// Sequencer: line store access, squared norm, per-component unit-length search.
// ----------------------------------------------------------------------------
module hmn_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  hmn_pkg::dp_status_t status,
  output hmn_pkg::dp_cmd_t    cmd
);
  import hmn_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RD1, S_WR, S_SQX, S_SQZ, S_MAG, S_MID, S_PL, S_PH,
    S_EMIT1, S_EMIT2, S_ADV
  } state_t;

  state_t     state;
  logic [1:0] comp;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd.comp = comp;
    cmd.op   = OP_NONE;
    case (state)
      S_IDLE:  cmd.op = in_valid ? OP_ACCEPT : OP_NONE;
      S_RD0:   cmd.op = OP_RD0;
      S_RD1:   cmd.op = OP_RD1;
      S_WR:    cmd.op = OP_WR;
      S_SQX:   cmd.op = OP_SQX;
      S_SQZ:   cmd.op = OP_SQZ;
      S_MAG:   cmd.op = OP_MAG;
      S_MID:   cmd.op = status.done ? OP_QSAVE : OP_MID;
      S_PL:    cmd.op = OP_PL;
      S_PH:    cmd.op = OP_PH;
      S_EMIT1: cmd.op = status.out_free ? OP_EMIT1 : OP_NONE;
      S_EMIT2: cmd.op = status.out_free ? OP_EMIT2 : OP_NONE;
      S_ADV:   cmd.op = OP_ADV;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      comp  <= COMP_X;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_RD0;
        end
        S_RD0: state <= S_RD1;
        S_RD1: state <= S_WR;
        S_WR: begin
          if (status.row_zero) state <= S_ADV;
          else if (status.border) state <= S_EMIT1;
          else state <= S_SQX;
        end
        S_SQX: state <= S_SQZ;
        S_SQZ: begin
          comp  <= COMP_X;
          state <= S_MAG;
        end
        S_MAG: state <= S_MID;
        S_MID: begin
          if (status.done) begin
            if (comp == COMP_Z) begin
              state <= S_EMIT1;
            end else begin
              comp  <= comp + 2'd1;
              state <= S_MAG;
            end
          end else begin
            state <= S_PL;
          end
        end
        S_PL: state <= S_PH;
        S_PH: state <= S_MID;
        S_EMIT1: begin
          if (status.out_free) state <= status.last_row ? S_EMIT2 : S_ADV;
        end
        S_EMIT2: begin
          if (status.out_free) state <= S_ADV;
        end
        S_ADV: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/hmn_datapath.sv]
// ----------------------------------------------------------------------------
// hmn_datapath
// Line stores, position counters, shared multiplier, search registers, output.
// ----------------------------------------------------------------------------
module hmn_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [7:0]          cfg_data,
  input  logic signed [15:0]  height,
  input  hmn_pkg::dp_cmd_t    cmd,
  output hmn_pkg::dp_status_t status,
  input  logic                out_stall,
  output logic                out_valid,
  output logic signed [15:0]  normal_x,
  output logic [14:0]         normal_y,
  output logic signed [15:0]  normal_z,
  output logic [6:0]          point_row,
  output logic [6:0]          point_col,
  output logic                last
);
  import hmn_pkg::*;

  logic [7:0]        grid;
  logic [7:0]        n;
  logic [ADDR_W-1:0] row, col;
  logic [H_W-1:0]    h;
  logic [H_W-1:0]    n_c;
  logic signed [16:0] nx, nz;
  logic [16:0]       ax, az, mag;
  logic [S_W-1:0]    s;
  logic [S_W-1:0]    m2;
  logic [29:0]       t2;
  logic [63:0]       acc;
  logic [Q_W-1:0]    lo, hi;
  logic [Q_W-1:0]    qx, qy, qz;
  logic [15:0]       mid_sum;
  logic [Q_W-1:0]    mid;
  logic [Q_W-1:0]    t;
  logic [29:0]       mul_a;
  logic [16:0]       mul_b;
  logic [46:0]       prod;
  logic [64:0]       sum;
  logic [64:0]       lim;
  logic [ADDR_W-1:0] old_raddr, new_raddr;
  logic [H_W-1:0]    old_rdata, new_rdata;
  logic              wr_en;
  logic [7:0]        col1, row1;
  logic              load1, load2;

  always_comb begin
    if (grid < GRID_MIN) n = GRID_MIN;
    else if (grid > GRID_MAX) n = GRID_MAX;
    else n = grid;
  end

  assign status.row_zero = (row == '0);
  assign status.last_row = ({1'b0, row} == n - 8'd1);
  assign status.border   = (row == 7'd1) || (col == '0) || ({1'b0, col} == n - 8'd1);
  assign status.done     = (lo == hi);
  assign status.out_free = !out_valid || !out_stall;

  always_comb begin
    old_raddr = col;
    new_raddr = col;
    if (cmd.op == OP_RD1) begin
      old_raddr = col - 7'd1;
      new_raddr = col + 7'd1;
    end
  end

  assign wr_en = (cmd.op == OP_WR);

  hmn_ram #(.WIDTH(H_W), .DEPTH(MAX_GRID)) u_older (
    .clk(clk), .we(wr_en), .waddr(col), .wdata(n_c),
    .raddr(old_raddr), .rdata(old_rdata)
  );

  hmn_ram #(.WIDTH(H_W), .DEPTH(MAX_GRID)) u_newer (
    .clk(clk), .we(wr_en), .waddr(col), .wdata(h),
    .raddr(new_raddr), .rdata(new_rdata)
  );

  assign ax = nx[16] ? 17'(-nx) : 17'(nx);
  assign az = nz[16] ? 17'(-nz) : 17'(nz);

  always_comb begin
    case (cmd.comp)
      COMP_X:  mag = ax;
      COMP_Y:  mag = NY_MAG;
      default: mag = az;
    endcase
  end

  assign mid_sum = {1'b0, lo} + {1'b0, hi} + 16'd1;
  assign mid     = mid_sum[15:1];
  assign t       = {mid[13:0], 1'b0} - 15'd1;

  always_comb begin
    mul_a = {13'd0, mag};
    mul_b = mag;
    case (cmd.op)
      OP_SQX: begin
        mul_a = {13'd0, ax};
        mul_b = ax;
      end
      OP_SQZ: begin
        mul_a = {13'd0, az};
        mul_b = az;
      end
      OP_MID: begin
        mul_a = {15'd0, t};
        mul_b = {2'd0, t};
      end
      OP_PL: begin
        mul_a = t2;
        mul_b = s[16:0];
      end
      OP_PH: begin
        mul_a = t2;
        mul_b = s[33:17];
      end
      default: ;
    endcase
  end

  assign prod = 47'(mul_a) * 47'(mul_b);
  assign sum  = {1'b0, acc} + {1'b0, prod[46:0], 17'd0};
  assign lim  = {1'b0, m2, 30'd0};

  assign col1 = {1'b0, col} + 8'd1;
  assign row1 = {1'b0, row} + 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid <= GRID_RST;
      row  <= '0;
      col  <= '0;
    end else if (cfg_write) begin
      grid <= cfg_data;
      row  <= '0;
      col  <= '0;
    end else if (cmd.op == OP_ADV) begin
      if (col1 >= n) begin
        col <= '0;
        row <= (row1 >= n) ? '0 : row1[6:0];
      end else begin
        col <= col1[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: h <= height;
      OP_RD1: begin
        n_c <= new_rdata;
        nx  <= 17'(signed'(old_rdata)) - 17'(signed'(h));
      end
      OP_WR:  nz <= 17'(signed'(old_rdata)) - 17'(signed'(new_rdata));
      OP_SQX: s <= prod[S_W-1:0];
      OP_SQZ: s <= s + prod[S_W-1:0] + NY_SQ;
      OP_MAG: begin
        m2 <= prod[S_W-1:0];
        lo <= '0;
        hi <= ONE_Q14;
      end
      OP_MID: t2 <= prod[29:0];
      OP_PL:  acc <= {17'd0, prod};
      OP_PH: begin
        if (sum <= lim) lo <= mid;
        else hi <= mid - 15'd1;
      end
      OP_QSAVE: begin
        case (cmd.comp)
          COMP_X:  qx <= lo;
          COMP_Y:  qy <= lo;
          default: qz <= lo;
        endcase
      end
      default: ;
    endcase
  end

  assign load1 = (cmd.op == OP_EMIT1);
  assign load2 = (cmd.op == OP_EMIT2);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load1 || load2) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      point_row <= row - 7'd1;
      point_col <= col;
      last      <= !status.last_row;
      if (status.border) begin
        normal_x <= '0;
        normal_y <= '0;
        normal_z <= '0;
      end else begin
        normal_x <= nx[16] ? -16'(qx) : 16'(qx);
        normal_y <= qy;
        normal_z <= nz[16] ? -16'(qz) : 16'(qz);
      end
    end else if (load2) begin
      point_row <= row;
      point_col <= col;
      last      <= 1'b1;
      normal_x  <= '0;
      normal_y  <= '0;
      normal_z  <= '0;
    end
  end

endmodule

[hw/rtl/hmn_checker.sv]
// ----------------------------------------------------------------------------
// hmn_checker
// Port-level checks on the normal stream output.
// ----------------------------------------------------------------------------
module hmn_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] normal_x,
  input logic [14:0]        normal_y,
  input logic signed [15:0] normal_z
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  a_border_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && normal_y == 15'd0 |-> normal_x == 16'sd0 && normal_z == 16'sd0)
    else $error("border word with nonzero normal");

  a_y_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> normal_y <= 15'd16384)
    else $error("normal_y above one");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

bind heightmap_normal_stream hmn_checker u_hmn_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z)
);
